// ----- sv/sepd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge presence detector - shared definitions
// Sizes, register codes and the types passed between the detector modules.
// ----------------------------------------------------------------------------
package sepd_pkg;

    // Frame geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int KERNEL_SIZE = 3;
    localparam int WIN_CELLS   = KERNEL_SIZE * KERNEL_SIZE;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = COL_W + 1;              // holds MAX_WIDTH itself
    localparam int MAX_HEIGHT  = 4096;
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int HGT_W       = ROW_W + 1;              // holds MAX_HEIGHT itself

    // Pixel and line store word
    localparam int PIX_W = 8;
    localparam int RAM_W = 2 * PIX_W;                    // {upper, middle}

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int THR_W      = 11;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam logic [THR_W-1:0]     THR_RESET    = THR_W'(60);
    localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = CFG_WID_W'(640);
    localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = CFG_HGT_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_THRESHOLD = 2'd0,
        REG_IMAGE_WIDTH    = 2'd1,
        REG_IMAGE_HEIGHT   = 2'd2
    } t_cfg_reg;

    // Gradient arithmetic
    localparam int GRAD_W = 11;                          // |g| <= 1020
    localparam int SQ_W   = 21;                          // gx^2 + gy^2
    localparam int TSQ_W  = 2 * THR_W;                   // threshold^2

    // Edge count and result compare
    localparam int COUNT_W = 23;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int CMP_W   = COUNT_W + 5;                // 20 * count

    typedef logic [PIX_W-1:0]     t_pix;
    typedef t_pix [WIN_CELLS-1:0] t_win;                 // row-major 3x3

    // Judgments asked of the gradient unit for one window
    typedef struct packed {
        logic judge_a;      // window as shifted in
        logic judge_b;      // same window after a zero pad column
        logic done;         // last judgment of the frame
    } t_judge_req;

endpackage

// ----- sv/sepd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module sepd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sepd_judge.sv -----
// ----------------------------------------------------------------------------
// Sobel gradient judge
// Two-stage unit: kernel sums, then squared magnitude against threshold^2.
// ----------------------------------------------------------------------------
module sepd_judge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sepd_pkg::t_win              i_win,
    input  sepd_pkg::t_judge_req        i_req,
    input  logic [sepd_pkg::THR_W-1:0]  i_thresh,
    output logic [1:0]                  o_hits,
    output logic                        o_done
);

    typedef struct packed {
        logic signed [sepd_pkg::GRAD_W-1:0] gx;
        logic signed [sepd_pkg::GRAD_W-1:0] gy;
    } t_grad;

    function automatic t_grad sobel(input sepd_pkg::t_win w);
        logic [sepd_pkg::GRAD_W-1:0] pos_x;
        logic [sepd_pkg::GRAD_W-1:0] neg_x;
        logic [sepd_pkg::GRAD_W-1:0] pos_y;
        logic [sepd_pkg::GRAD_W-1:0] neg_y;
        t_grad g;
        pos_x = sepd_pkg::GRAD_W'(w[2]) + (sepd_pkg::GRAD_W'(w[5]) << 1)
              + sepd_pkg::GRAD_W'(w[8]);
        neg_x = sepd_pkg::GRAD_W'(w[0]) + (sepd_pkg::GRAD_W'(w[3]) << 1)
              + sepd_pkg::GRAD_W'(w[6]);
        pos_y = sepd_pkg::GRAD_W'(w[6]) + (sepd_pkg::GRAD_W'(w[7]) << 1)
              + sepd_pkg::GRAD_W'(w[8]);
        neg_y = sepd_pkg::GRAD_W'(w[0]) + (sepd_pkg::GRAD_W'(w[1]) << 1)
              + sepd_pkg::GRAD_W'(w[2]);
        // sums stay below 1024, so the sign bit is clear
        g.gx = $signed(pos_x) - $signed(neg_x);
        g.gy = $signed(pos_y) - $signed(neg_y);
        return g;
    endfunction

    function automatic logic [sepd_pkg::SQ_W-1:0] mag2(input t_grad g);
        logic signed [2*sepd_pkg::GRAD_W-1:0] px;
        logic signed [2*sepd_pkg::GRAD_W-1:0] py;
        px = g.gx * g.gx;
        py = g.gy * g.gy;
        return sepd_pkg::SQ_W'(px) + sepd_pkg::SQ_W'(py);
    endfunction

    sepd_pkg::t_win          win_b;
    t_grad                   r_ga;
    t_grad                   r_gb;
    sepd_pkg::t_judge_req    r_req;
    logic [sepd_pkg::TSQ_W-1:0] thr_sq;
    logic                    hit_a;
    logic                    hit_b;
    logic [1:0]              r_hits;
    logic                    r_done;

    // window after the right-hand zero pad column is shifted in
    always_comb begin
        win_b    = '0;
        win_b[0] = i_win[1];
        win_b[1] = i_win[2];
        win_b[3] = i_win[4];
        win_b[4] = i_win[5];
        win_b[6] = i_win[7];
        win_b[7] = i_win[8];
    end

    // stage 1: kernel sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else begin
            r_req <= i_req;
        end
        r_ga <= sobel(i_win);
        r_gb <= sobel(win_b);
    end

    // stage 2: squares and compare, exact against the square root
    always_comb begin
        thr_sq = sepd_pkg::TSQ_W'(i_thresh) * sepd_pkg::TSQ_W'(i_thresh);
        hit_a  = r_req.judge_a && (sepd_pkg::TSQ_W'(mag2(r_ga)) > thr_sq);
        hit_b  = r_req.judge_b && (sepd_pkg::TSQ_W'(mag2(r_gb)) > thr_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_done <= 1'b0;
        end else begin
            r_hits <= 2'(hit_a) + 2'(hit_b);
            r_done <= r_req.done;
        end
    end

    assign o_hits = r_hits;
    assign o_done = r_done;

endmodule

// ----- sv/sobel_edge_presence_detector.sv -----
// ----------------------------------------------------------------------------
// Sobel edge presence detector
// Counts Sobel edge pixels in a raster frame and flags frames with many edges.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while the block does not stall.
// After the last pixel of a frame the input stalls while the single read port
// of the line store is swept once more over image_width columns (clamped to
// 1..1024) to judge the bottom row against its zero pad; the last sweep cycle
// also waits until the previous result has been taken. The frame's result
// (edge_count, object_present) passes the window, the gradient judge, the edge
// total and the result register, and is held until taken; pixels of the next
// frame are taken meanwhile. After reset the line store is cleared, one entry
// per cycle, stalling the input until done; configuration writes are taken at
// any time and act at once. An edge pixel is one whose gx^2 + gy^2 exceeds
// edge_threshold^2; object_present is set if 20 * edge_count > width * height.
// ----------------------------------------------------------------------------
module sobel_edge_presence_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel requests
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sepd_pkg::PIX_W-1:0]        i_pixel,
    // frame results
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_object_present,
    output logic [sepd_pkg::COUNT_W-1:0]      o_edge_count,
    // configuration writes
    input  logic                              i_cfg_wen,
    input  logic [sepd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sepd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FLUSH
    } t_state;

    // control carried with a request into the window stage
    typedef struct packed {
        logic                 vld;
        logic                 wr;       // write back the line store
        logic                 top_en;   // upper row lies inside the frame
        logic                 mid_en;   // middle row lies inside the frame
        logic                 clr;      // first column: start from an empty window
        sepd_pkg::t_judge_req req;
    } t_s1_ctl;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [sepd_pkg::THR_W-1:0]     r_thresh;
    logic [sepd_pkg::CFG_WID_W-1:0] r_width;
    logic [sepd_pkg::CFG_HGT_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= sepd_pkg::THR_RESET;
            r_width  <= sepd_pkg::WIDTH_RESET;
            r_height <= sepd_pkg::HEIGHT_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                sepd_pkg::REG_EDGE_THRESHOLD: begin
                    r_thresh <= i_cfg_data[sepd_pkg::THR_W-1:0];
                end
                sepd_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[sepd_pkg::CFG_WID_W-1:0];
                end
                sepd_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[sepd_pkg::CFG_HGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamped frame size: zero reads as one, oversize as the maximum
    logic [sepd_pkg::WID_W-1:0] w_eff;
    logic [sepd_pkg::HGT_W-1:0] h_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = sepd_pkg::WID_W'(1);
        end else if (32'(r_width) > sepd_pkg::MAX_WIDTH) begin
            w_eff = sepd_pkg::WID_W'(sepd_pkg::MAX_WIDTH);
        end else begin
            w_eff = sepd_pkg::WID_W'(r_width);
        end
        if (r_height == '0) begin
            h_eff = sepd_pkg::HGT_W'(1);
        end else if (32'(r_height) > sepd_pkg::MAX_HEIGHT) begin
            h_eff = sepd_pkg::HGT_W'(sepd_pkg::MAX_HEIGHT);
        end else begin
            h_eff = sepd_pkg::HGT_W'(r_height);
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: clear pass, pixel run, bottom-row sweep
    // ---------------------------------------------------------------------
    t_state                     r_state;
    logic [sepd_pkg::COL_W-1:0] r_col;      // pixel column, also sweep column
    logic [sepd_pkg::ROW_W-1:0] r_row;
    logic [sepd_pkg::COL_W-1:0] r_clr;
    logic                       r_ftop;     // last row had a row above it
    logic                       r_pend;     // a frame result is in the pipe
    logic                       r_out_valid;
    logic                       r_res_vld;

    logic row_end;
    logic frame_end;
    logic out_free;
    logic in_acc;
    logic fl_issue;

    always_comb begin
        row_end   = (sepd_pkg::WID_W'(r_col) + sepd_pkg::WID_W'(1)) >= w_eff;
        frame_end = row_end
                  && ((sepd_pkg::HGT_W'(r_row) + sepd_pkg::HGT_W'(1)) >= h_eff);
        // the output register must be free by the time the result lands
        out_free  = !r_pend && (!r_out_valid || !i_stall);
        in_acc    = i_valid && (r_state == ST_RUN);
        fl_issue  = (r_state == ST_FLUSH) && (!row_end || out_free);
    end

    assign o_stall = (r_state != ST_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_col   <= '0;
            r_row   <= '0;
            r_clr   <= '0;
            r_ftop  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + sepd_pkg::COL_W'(1);
                    if (r_clr == sepd_pkg::COL_W'(sepd_pkg::MAX_WIDTH - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (in_acc) begin
                        if (!row_end) begin
                            r_col <= r_col + sepd_pkg::COL_W'(1);
                        end else begin
                            r_col <= '0;
                            if (!frame_end) begin
                                r_row <= r_row + sepd_pkg::ROW_W'(1);
                            end else begin
                                r_row   <= '0;
                                r_ftop  <= (r_row != '0);
                                r_state <= ST_FLUSH;
                            end
                        end
                    end
                end
                ST_FLUSH: begin
                    if (fl_issue) begin
                        if (row_end) begin
                            r_col   <= '0;
                            r_state <= ST_RUN;
                        end else begin
                            r_col <= r_col + sepd_pkg::COL_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
            if (fl_issue && row_end) begin
                r_pend <= 1'b1;
            end else if (r_res_vld) begin
                r_pend <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Request into stage 1; line store read is issued at r_col
    // ---------------------------------------------------------------------
    t_s1_ctl                    n_s1;
    t_s1_ctl                    r_s1;
    logic [sepd_pkg::COL_W-1:0] r_s1_col;
    sepd_pkg::t_pix             r_s1_pix;

    always_comb begin
        n_s1 = '0;
        if (in_acc) begin
            n_s1.vld         = 1'b1;
            n_s1.wr          = 1'b1;
            n_s1.top_en      = (r_row > sepd_pkg::ROW_W'(1));
            n_s1.mid_en      = (r_row != '0);
            n_s1.clr         = (r_col == '0);
            n_s1.req.judge_a = (r_row != '0) && (r_col != '0);
            n_s1.req.judge_b = (r_row != '0) && row_end;
        end else if (fl_issue) begin
            // bottom row: upper store holds the row above, middle the last row
            n_s1.vld         = 1'b1;
            n_s1.top_en      = r_ftop;
            n_s1.mid_en      = 1'b1;
            n_s1.clr         = (r_col == '0);
            n_s1.req.judge_a = (r_col != '0);
            n_s1.req.judge_b = row_end;
            n_s1.req.done    = row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
        r_s1_col <= r_col;
        r_s1_pix <= in_acc ? i_pixel : '0;     // bottom pad reads zero
    end

    // ---------------------------------------------------------------------
    // Line store: {upper, middle} per column, with same-cycle bypass
    // ---------------------------------------------------------------------
    logic                       ram_we;
    logic [sepd_pkg::COL_W-1:0] ram_waddr;
    logic [sepd_pkg::RAM_W-1:0] ram_wdata;
    logic [sepd_pkg::RAM_W-1:0] ram_q;
    logic                       r_byp;
    logic [sepd_pkg::RAM_W-1:0] r_byp_data;
    logic [sepd_pkg::RAM_W-1:0] rd;
    sepd_pkg::t_pix             up_raw;
    sepd_pkg::t_pix             mid_raw;

    always_comb begin
        rd      = r_byp ? r_byp_data : ram_q;
        up_raw  = rd[sepd_pkg::RAM_W-1:sepd_pkg::PIX_W];
        mid_raw = rd[sepd_pkg::PIX_W-1:0];
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            // the middle row moves up, the new pixel becomes the middle row
            ram_we    = r_s1.vld && r_s1.wr;
            ram_waddr = r_s1_col;
            ram_wdata = {mid_raw, r_s1_pix};
        end
    end

    // a one-pixel-wide frame reads the column that is being written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= ram_we && (ram_waddr == r_col);
        end
        r_byp_data <= ram_wdata;
    end

    sepd_ram #(
        .WIDTH (sepd_pkg::RAM_W),
        .DEPTH (sepd_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_wen   (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // ---------------------------------------------------------------------
    // 3x3 window: new column enters on the right, outside rows read zero
    // ---------------------------------------------------------------------
    sepd_pkg::t_win       base;
    sepd_pkg::t_win       n_win;
    sepd_pkg::t_win       r_win;
    sepd_pkg::t_judge_req r_jreq;

    always_comb begin
        base     = r_s1.clr ? '0 : r_win;
        n_win[0] = base[1];
        n_win[1] = base[2];
        n_win[2] = r_s1.top_en ? up_raw : '0;
        n_win[3] = base[4];
        n_win[4] = base[5];
        n_win[5] = r_s1.mid_en ? mid_raw : '0;
        n_win[6] = base[7];
        n_win[7] = base[8];
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jreq <= '0;
        end else begin
            r_jreq <= r_s1.req;
        end
        if (r_s1.vld) begin
            r_win <= n_win;
        end
    end

    logic [1:0] j_hits;
    logic       j_done;

    sepd_judge u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (r_win),
        .i_req    (r_jreq),
        .i_thresh (r_thresh),
        .o_hits   (j_hits),
        .o_done   (j_done)
    );

    // ---------------------------------------------------------------------
    // Edge total, saturating; the frame's last judgment hands it off
    // ---------------------------------------------------------------------
    logic [sepd_pkg::COUNT_W-1:0] r_total;
    logic [sepd_pkg::COUNT_W-1:0] r_res_cnt;
    logic [sepd_pkg::COUNT_W:0]   cnt_sum;
    logic [sepd_pkg::COUNT_W-1:0] cnt_sat;

    always_comb begin
        cnt_sum = (sepd_pkg::COUNT_W+1)'(r_total) + (sepd_pkg::COUNT_W+1)'(j_hits);
        cnt_sat = (cnt_sum > (sepd_pkg::COUNT_W+1)'(sepd_pkg::COUNT_MAX))
                ? sepd_pkg::COUNT_MAX : cnt_sum[sepd_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= j_done;
            r_total   <= j_done ? '0 : cnt_sat;
        end
        if (j_done) begin
            r_res_cnt <= cnt_sat;
        end
    end

    // ---------------------------------------------------------------------
    // Result register: 20 * count > width * height
    // ---------------------------------------------------------------------
    logic [sepd_pkg::WID_W+sepd_pkg::HGT_W-1:0] area;
    logic [sepd_pkg::CMP_W-1:0]                 cnt20;
    logic                                       obj;
    logic                                       r_out_obj;
    logic [sepd_pkg::COUNT_W-1:0]               r_out_cnt;

    always_comb begin
        area  = w_eff * h_eff;
        cnt20 = (sepd_pkg::CMP_W'(r_res_cnt) << 4) + (sepd_pkg::CMP_W'(r_res_cnt) << 2);
        obj   = cnt20 > sepd_pkg::CMP_W'(area);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_res_vld) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_res_vld) begin
            r_out_obj <= obj;
            r_out_cnt <= r_res_cnt;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_object_present = r_out_obj;
    assign o_edge_count     = r_out_cnt;

endmodule

// ----- sv/sepd_checker.sv -----
// ----------------------------------------------------------------------------
// Sobel edge presence detector - port checker
// Watches the top-level ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module sepd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_object_present,
    input logic [sepd_pkg::COUNT_W-1:0]      o_edge_count
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_edge_count) && $stable(o_object_present))
        else $error("result payload changed while stalled");

    // the presence flag needs at least one edge pixel
    a_obj_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_object_present |-> o_edge_count != '0)
        else $error("object flagged with zero edge count");

    // the line store clear holds off pixels right after reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_stall)
        else $error("pixel input open during line store clear");

    // one result per frame: a taken result is not followed at once by another
    a_one_per_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("back-to-back frame results");

endmodule

bind sobel_edge_presence_detector sepd_checker u_sepd_checker (.*);
